FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
// all checks sample on the rising edge of clk_i and are off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge
`define SPBQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spbq check failed");

// condition must never be seen
`define SPBQ_ASSERT_NEVER(label, cond) \
  `SPBQ_ASSERT(label, !(cond))

`endif

FILE: hdl/spbq_pkg.sv
// ----------------------------------------------------------------------------
// spbq_pkg
// shared widths, link markers, request and status codes, control structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spbq_pkg;

  // pool geometry
  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = SLOT_W + 1;

  // link markers: top bit set means not a slot index
  localparam logic [LINK_W-1:0] LINK_END    = {LINK_W{1'b1}};
  localparam logic [LINK_W-1:0] LINK_UNUSED = {{(LINK_W-1){1'b1}}, 1'b0};
  localparam logic [LINK_W-1:0] CUR_IDLE    = {LINK_W{1'b1}};

  // request kinds
  localparam logic [2:0] K_ALLOC   = 3'd0;
  localparam logic [2:0] K_COMMIT  = 3'd1;
  localparam logic [2:0] K_TAKE    = 3'd2;
  localparam logic [2:0] K_NEXT    = 3'd3;
  localparam logic [2:0] K_RELEASE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } spbq_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
  } spbq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic more;
  } spbq_sts_t;

  // link table contents after reset
  function automatic logic [LINK_W-1:0] link_reset(input logic [SLOT_W-1:0] addr);
    logic [LINK_W-1:0] val;
    if (addr == SLOT_W'(SLOTS - 1)) begin
      val = LINK_END;
    end else begin
      val = {1'b0, addr} + LINK_W'(1);
    end
    return val;
  endfunction

endpackage

FILE: hdl/spbq_req_if.sv
// ----------------------------------------------------------------------------
// spbq_req_if
// request channel: valid/ready handshake with kind and slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spbq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink (input valid, input kind, input slot, output ready);
endinterface

FILE: hdl/spbq_rsp_if.sv
// ----------------------------------------------------------------------------
// spbq_rsp_if
// response channel: valid/ready handshake with slot, count and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spbq_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot_out;
  logic [8:0] count;
  logic [1:0] status;

  modport source (output valid, output slot_out, output count, output status, input ready);
  modport sink (input valid, input slot_out, input count, input status, output ready);
endinterface

FILE: hdl/slot_pool_batch_queue_unit.sv
// ----------------------------------------------------------------------------
// slot_pool_batch_queue_unit
// slot pool with pending stack and batch dequeue
// req_i carries one request beat: kind (allocate, commit, take, next,
// release) and, for commit, a slot index. rsp_o returns exactly one beat per
// request: slot_out, count and status (ok, empty/exhausted, bad).
// Each request is accepted and then stepped until its response is loaded;
// a take that detaches n pending slots steps once per slot, one link table
// access per slot, and every other request needs a single step.
// One request is in flight at a time, so no beat enters until the previous
// response is loaded; ready is high while idle, so the next beat can enter
// while the previous response still sits in the output register. The link
// table port allows one read and one write per cycle.
// A stalled receiver holds the response register; the block then finishes
// the request in flight only once the register frees, and takes no further
// beat meanwhile.
// Reset: free list holds every slot in order, nothing pending, no batch held.
// Per-entry valid bits give the link table its reset chain at once, so the
// block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module slot_pool_batch_queue_unit import spbq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  spbq_req_if.sink   req_i,
  spbq_rsp_if.source rsp_o
);

  spbq_cmd_t cmd;
  spbq_sts_t sts;

  // sequencer
  spbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // lists, link table and response register
  spbq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (req_i.kind),
    .slot_i      (req_i.slot),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .slot_out_o  (rsp_o.slot_out),
    .count_o     (rsp_o.count),
    .status_o    (rsp_o.status)
  );

  // checks
  `SPBQ_ASSERT(a_busy_after_accept, cmd.accept |=> !req_i.ready)
  `SPBQ_ASSERT(a_rsp_from_step, $rose(rsp_o.valid) |-> $past(cmd.step))
  `SPBQ_ASSERT_NEVER(a_count_not_ok, rsp_o.valid && |rsp_o.count && (rsp_o.status != ST_OK))
  `SPBQ_ASSERT_NEVER(a_status_code, rsp_o.valid && (rsp_o.status > ST_BAD))

endmodule

FILE: hdl/spbq_link_mem.sv
// ----------------------------------------------------------------------------
// spbq_link_mem
// link table: one write and one registered read per cycle, per-entry valid
// bits so that unwritten entries read back as their reset chain value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbq_link_mem import spbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [LINK_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]  vld_q;
  logic [LINK_W-1:0] rd_mem_q;
  logic [LINK_W-1:0] rd_def_q;
  logic              rd_vld_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_mem_q <= mem_q[raddr_i];
      rd_def_q <= link_reset(raddr_i);
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  // unwritten entries show the reset chain
  assign rdata_o = rd_vld_q ? rd_mem_q : rd_def_q;

endmodule

FILE: hdl/spbq_ctrl.sv
// ----------------------------------------------------------------------------
// spbq_ctrl
// sequencer: takes a request beat, then steps the datapath until the
// response is loaded into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbq_ctrl import spbq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  spbq_sts_t sts_i,
  output spbq_cmd_t cmd_o
);

  spbq_state_e state_q, state_d;

  // handshake and commands
  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.step   = (state_q == S_EXEC) && sts_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_o.step && !sts_i.more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/spbq_dp.sv
// ----------------------------------------------------------------------------
// spbq_dp
// datapath: list heads, batch registers, link table and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbq_dp import spbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spbq_cmd_t         cmd_i,
  output spbq_sts_t         sts_o,
  input  logic [2:0]        kind_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [SLOT_W-1:0] slot_out_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [1:0]        status_o
);

  // request latch and walk registers
  logic [2:0]        kind_q, kind_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  // pool state
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [LINK_W-1:0] pend_head_q, pend_head_d;
  logic [SLOT_W-1:0] first_q, first_d;
  logic [SLOT_W-1:0] last_q, last_d;
  logic [LINK_W-1:0] cursor_q, cursor_d;
  logic              held_q, held_d;
  // output register
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [1:0]        out_st_q, out_st_d;
  // link table port
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [LINK_W-1:0] wdata;
  logic              re;
  logic [SLOT_W-1:0] raddr;
  logic [LINK_W-1:0] rdata;
  // step results
  logic [CNT_W-1:0]  cnt_inc;
  logic              take_more;
  logic              fin;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_cnt;
  logic [1:0]        res_st;

  spbq_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // reversal walk continues while the next link is a slot and the pool is not exhausted
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign take_more = (kind_q == K_TAKE) && !held_q && !pend_head_q[SLOT_W]
                     && !rdata[SLOT_W] && (cnt_inc != CNT_W'(SLOTS));

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.more     = take_more;

  // request decode and execution
  always_comb begin
    kind_d      = kind_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    free_head_d = free_head_q;
    pend_head_d = pend_head_q;
    first_d     = first_q;
    last_d      = last_q;
    cursor_d    = cursor_q;
    held_d      = held_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    fin         = 1'b0;
    res_slot    = '0;
    res_cnt     = '0;
    res_st      = ST_OK;

    // accept: latch request and start the link read for alloc, commit, take and next
    if (cmd_i.accept) begin
      kind_d = kind_i;
      slot_d = slot_i;
      re     = 1'b1;
      case (kind_i)
        K_ALLOC:  raddr = free_head_q[SLOT_W-1:0];
        K_COMMIT: raddr = slot_i;
        K_TAKE: begin
          raddr  = pend_head_q[SLOT_W-1:0];
          prev_d = LINK_END;
          cnt_d  = '0;
          cur_d  = pend_head_q[SLOT_W-1:0];
          if (!held_q && !pend_head_q[SLOT_W]) begin
            last_d = pend_head_q[SLOT_W-1:0];
          end
        end
        K_NEXT:   raddr = cursor_q[SLOT_W-1:0];
        default: begin
          re = 1'b0;
        end
      endcase
    end

    // step: link data is available
    if (cmd_i.step) begin
      fin = !take_more;
      case (kind_q)
        K_ALLOC: begin
          if (free_head_q[SLOT_W]) begin
            res_st = ST_EMPTY;
          end else begin
            free_head_d = rdata;
            we          = 1'b1;
            waddr       = free_head_q[SLOT_W-1:0];
            wdata       = LINK_UNUSED;
            res_slot    = free_head_q[SLOT_W-1:0];
          end
        end
        K_COMMIT: begin
          if (rdata != LINK_UNUSED) begin
            res_st = ST_BAD;
          end else begin
            we          = 1'b1;
            waddr       = slot_q;
            wdata       = pend_head_q;
            pend_head_d = {1'b0, slot_q};
          end
        end
        K_TAKE: begin
          if (held_q) begin
            res_st = ST_BAD;
          end else if (pend_head_q[SLOT_W]) begin
            res_st = ST_EMPTY;
          end else begin
            // reverse one link
            we     = 1'b1;
            waddr  = cur_q;
            wdata  = prev_q;
            prev_d = {1'b0, cur_q};
            cnt_d  = cnt_inc;
            if (take_more) begin
              cur_d = rdata[SLOT_W-1:0];
              re    = 1'b1;
              raddr = rdata[SLOT_W-1:0];
            end else begin
              first_d     = cur_q;
              pend_head_d = LINK_END;
              cursor_d    = CUR_IDLE;
              held_d      = 1'b1;
              res_cnt     = cnt_inc;
            end
          end
        end
        K_NEXT: begin
          if (!held_q) begin
            res_st = ST_BAD;
          end else if (cursor_q == CUR_IDLE) begin
            cursor_d = {1'b0, first_q};
            res_slot = first_q;
          end else if (rdata[SLOT_W]) begin
            res_st = ST_EMPTY;
          end else begin
            cursor_d = rdata;
            res_slot = rdata[SLOT_W-1:0];
          end
        end
        K_RELEASE: begin
          if (!held_q) begin
            res_st = ST_BAD;
          end else begin
            we          = 1'b1;
            waddr       = last_q;
            wdata       = free_head_q;
            free_head_d = {1'b0, first_q};
            held_d      = 1'b0;
            cursor_d    = CUR_IDLE;
          end
        end
        default: begin
          res_st = ST_BAD;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    if (fin) begin
      out_valid_d = 1'b1;
      out_slot_d  = res_slot;
      out_cnt_d   = res_cnt;
      out_st_d    = res_st;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      pend_head_q <= LINK_END;
      first_q     <= '0;
      last_q      <= '0;
      cursor_q    <= CUR_IDLE;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      pend_head_q <= pend_head_d;
      first_q     <= first_d;
      last_q      <= last_d;
      cursor_q    <= cursor_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    cnt_q      <= cnt_d;
    out_slot_q <= out_slot_d;
    out_cnt_q  <= out_cnt_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign slot_out_o  = out_slot_q;
  assign count_o     = out_cnt_q;
  assign status_o    = out_st_q;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the slot pool with pending stack and batch dequeue:
// a directed table of requests, then random request streams and one full
// drain of the pool, each response checked against a cycle-free model of the
// free list, pending stack and held batch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import spbq_pkg::*; ();

  // request kinds the block rejects
  localparam logic [2:0] K_RSVD5 = 3'd5;
  localparam logic [2:0] K_RSVD6 = 3'd6;
  localparam logic [2:0] K_RSVD7 = 3'd7;

  localparam int RAND_ITEMS     = 1300;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;
  localparam int DIR_N          = 25;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] slot;
  } pool_req_t;

  typedef struct packed {
    logic [7:0] slot_out;
    logic [8:0] count;
    logic [1:0] status;
  } pool_rsp_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] slot;
    logic       typed;
    logic [7:0] slot_out;
    logic [8:0] count;
    logic [1:0] status;
  } dir_row_t;

  // directed requests; typed rows carry their response, the rest use the model
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{K_NEXT,    8'd0,   1'b1, 8'd0, 9'd0, ST_BAD},   // next with no batch
    '{K_RELEASE, 8'hFF,  1'b1, 8'd0, 9'd0, ST_BAD},   // release with no batch
    '{K_TAKE,    8'd0,   1'b1, 8'd0, 9'd0, ST_EMPTY}, // nothing pending
    '{K_COMMIT,  8'd0,   1'b1, 8'd0, 9'd0, ST_BAD},   // free slot, lowest
    '{K_COMMIT,  8'd255, 1'b1, 8'd0, 9'd0, ST_BAD},   // free slot, highest
    '{K_ALLOC,   8'hFF,  1'b1, 8'd0, 9'd0, ST_OK},
    '{K_ALLOC,   8'd0,   1'b1, 8'd1, 9'd0, ST_OK},
    '{K_COMMIT,  8'd1,   1'b1, 8'd0, 9'd0, ST_OK},
    '{K_COMMIT,  8'd1,   1'b1, 8'd0, 9'd0, ST_BAD},   // committed twice
    '{K_COMMIT,  8'd0,   1'b1, 8'd0, 9'd0, ST_OK},
    '{K_RSVD5,   8'd0,   1'b1, 8'd0, 9'd0, ST_BAD},
    '{K_RSVD6,   8'hAA,  1'b1, 8'd0, 9'd0, ST_BAD},
    '{K_RSVD7,   8'hFF,  1'b1, 8'd0, 9'd0, ST_BAD},
    '{K_TAKE,    8'd0,   1'b1, 8'd0, 9'd2, ST_OK},
    '{K_TAKE,    8'd0,   1'b1, 8'd0, 9'd0, ST_BAD},   // batch still held
    '{K_NEXT,    8'd0,   1'b1, 8'd1, 9'd0, ST_OK},    // arrival order
    '{K_NEXT,    8'd0,   1'b1, 8'd0, 9'd0, ST_OK},
    '{K_NEXT,    8'd0,   1'b1, 8'd0, 9'd0, ST_EMPTY}, // past the last slot
    '{K_NEXT,    8'hFF,  1'b1, 8'd0, 9'd0, ST_EMPTY}, // cursor stays put
    '{K_COMMIT,  8'd0,   1'b1, 8'd0, 9'd0, ST_BAD},   // slot in the batch
    '{K_RELEASE, 8'd0,   1'b1, 8'd0, 9'd0, ST_OK},
    '{K_ALLOC,   8'd0,   1'b0, 8'd0, 9'd0, ST_OK},
    '{K_ALLOC,   8'd0,   1'b0, 8'd0, 9'd0, ST_OK},
    '{K_COMMIT,  8'd2,   1'b1, 8'd0, 9'd0, ST_BAD},   // still on the free list
    '{K_NEXT,    8'd0,   1'b1, 8'd0, 9'd0, ST_BAD}    // batch gone
  };

  logic clk_i;
  logic rst_ni;

  spbq_req_if req_if ();
  spbq_rsp_if rsp_if ();

  slot_pool_batch_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // pool model state
  logic [LINK_W-1:0] pool_link [SLOTS];
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] pend_head;
  logic [LINK_W-1:0] walk_cursor;
  logic [SLOT_W-1:0] batch_first;
  logic [SLOT_W-1:0] batch_last;
  logic              batch_held;
  logic [SLOT_W-1:0] owned_q [$];   // allocated, not yet committed

  pool_rsp_t rsp_due_q [$];
  int        fault_cnt   = 0;
  bit        tx_quiet    = 1'b0;
  bit        rx_quiet    = 1'b0;
  bit        rx_hold_req = 1'b0;

  function automatic bit is_slot(input logic [LINK_W-1:0] v);
    return v < LINK_W'(SLOTS);
  endfunction

  task automatic pool_reset();
    for (int i = 0; i < SLOTS; i++) begin
      pool_link[i] = (i == SLOTS - 1) ? LINK_END : LINK_W'(i + 1);
    end
    free_head   = '0;
    pend_head   = LINK_END;
    walk_cursor = CUR_IDLE;
    batch_first = '0;
    batch_last  = '0;
    batch_held  = 1'b0;
    owned_q.delete();
  endtask

  // one request applied to the pool model, response returned
  function automatic pool_rsp_t pool_predict(input pool_req_t rq);
    pool_rsp_t         r;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    logic [CNT_W-1:0]  n;
    r = '0;
    r.status = ST_OK;
    case (rq.kind)
      K_ALLOC: begin
        if (!is_slot(free_head)) begin
          r.status = ST_EMPTY;
        end else begin
          r.slot_out = free_head[SLOT_W-1:0];
          free_head = pool_link[r.slot_out];
          pool_link[r.slot_out] = LINK_UNUSED;
          owned_q.push_back(r.slot_out);
        end
      end
      K_COMMIT: begin
        if (!is_slot(LINK_W'(rq.slot)) || pool_link[rq.slot] != LINK_UNUSED) begin
          r.status = ST_BAD;
        end else begin
          pool_link[rq.slot] = pend_head;
          pend_head = LINK_W'(rq.slot);
          for (int i = 0; i < owned_q.size(); i++) begin
            if (owned_q[i] == rq.slot) begin
              owned_q.delete(i);
              break;
            end
          end
        end
      end
      K_TAKE: begin
        if (batch_held) begin
          r.status = ST_BAD;
        end else if (!is_slot(pend_head)) begin
          r.status = ST_EMPTY;
        end else begin
          // reverse the pending stack into arrival order
          prev = LINK_END;
          cur = pend_head;
          n = '0;
          batch_last = cur[SLOT_W-1:0];
          for (int g = 0; g < SLOTS; g++) begin
            nxt = pool_link[cur[SLOT_W-1:0]];
            pool_link[cur[SLOT_W-1:0]] = prev;
            prev = cur;
            n = n + 1'b1;
            if (!is_slot(nxt)) break;
            cur = nxt;
          end
          batch_first = prev[SLOT_W-1:0];
          pend_head = LINK_END;
          walk_cursor = CUR_IDLE;
          batch_held = 1'b1;
          r.count = n;
        end
      end
      K_NEXT: begin
        if (!batch_held) begin
          r.status = ST_BAD;
        end else if (walk_cursor == CUR_IDLE) begin
          walk_cursor = {1'b0, batch_first};
          r.slot_out = batch_first;
        end else if (!is_slot(walk_cursor) ||
                     !is_slot(pool_link[walk_cursor[SLOT_W-1:0]])) begin
          r.status = ST_EMPTY;
        end else begin
          walk_cursor = pool_link[walk_cursor[SLOT_W-1:0]];
          r.slot_out = walk_cursor[SLOT_W-1:0];
        end
      end
      K_RELEASE: begin
        if (!batch_held || !is_slot(LINK_W'(batch_last))) begin
          r.status = ST_BAD;
        end else begin
          // splice the batch onto the front of the free list
          pool_link[batch_last] = free_head;
          free_head = {1'b0, batch_first};
          batch_held = 1'b0;
          walk_cursor = CUR_IDLE;
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // random request, weighted towards well-formed alloc/commit/take/walk flows
  function automatic pool_req_t pick_request();
    pool_req_t rq;
    int        r;
    rq.slot = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 34) begin
      rq.kind = K_ALLOC;
    end else if (r < 64) begin
      rq.kind = K_COMMIT;
      if (owned_q.size() > 0 && $urandom_range(0, 99) < 85) begin
        rq.slot = owned_q[$urandom_range(0, owned_q.size() - 1)];
      end
    end else if (r < 72) begin
      rq.kind = K_TAKE;
    end else if (r < 88) begin
      rq.kind = K_NEXT;
    end else if (r < 96) begin
      rq.kind = K_RELEASE;
    end else begin
      case ($urandom_range(0, 2))
        0:       rq.kind = K_RSVD5;
        1:       rq.kind = K_RSVD6;
        default: rq.kind = K_RSVD7;
      endcase
    end
    return rq;
  endfunction

  // offer one request beat, record its expected response once accepted
  task automatic send_beat(input pool_req_t rq, input bit typed, input pool_rsp_t typed_rsp);
    pool_rsp_t pred;
    int        gap;
    req_if.valid <= 1'b1;
    req_if.kind  <= rq.kind;
    req_if.slot  <= rq.slot;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = pool_predict(rq);
    rsp_due_q.push_back(typed ? typed_rsp : pred);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_kind(input logic [2:0] k);
    pool_req_t rq;
    rq.kind = k;
    rq.slot = 8'($urandom);
    send_beat(rq, 1'b0, '0);
  endtask

  // empty the pool, commit every slot, take the full batch, walk and release it
  task automatic full_pool_cycle();
    pool_req_t rq;
    if (batch_held) send_kind(K_RELEASE);
    while (is_slot(free_head)) send_kind(K_ALLOC);
    send_kind(K_ALLOC);
    while (owned_q.size() > 0) begin
      rq.kind = K_COMMIT;
      rq.slot = owned_q[$urandom_range(0, owned_q.size() - 1)];
      send_beat(rq, 1'b0, '0);
    end
    send_kind(K_TAKE);
    repeat (SLOTS + 2) send_kind(K_NEXT);
    send_kind(K_RELEASE);
  endtask

  task automatic note_fault(input string what, input pool_rsp_t want, input pool_rsp_t got);
    fault_cnt++;
    if (fault_cnt <= REPORT_MAX) begin
      $display("%0t %s: exp slot %0d count %0d status %0d, got slot %0d count %0d status %0d",
               $realtime, what, want.slot_out, want.count, want.status,
               got.slot_out, got.count, got.status);
    end
  endtask

  // response check against the oldest expectation
  always @(posedge clk_i) begin
    pool_rsp_t got;
    pool_rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = {rsp_if.slot_out, rsp_if.count, rsp_if.status};
      if (rsp_due_q.size() == 0) begin
        note_fault("response beat with none due", '0, got);
      end else begin
        want = rsp_due_q.pop_front();
        if (got.slot_out !== want.slot_out || got.count !== want.count ||
            got.status !== want.status) begin
          note_fault("response field wrong", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d responses outstanding", rsp_due_q.size());
      $display("slot_pool_batch_queue_unit: mismatch");
      $finish;
    end
  end

  // response side: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 150 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // request side and end of run
  initial begin
    pool_req_t rq;
    pool_rsp_t row_rsp;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind = K_ALLOC;
    req_if.slot = '0;
    pool_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      rq = {DIR_TAB[i].kind, DIR_TAB[i].slot};
      row_rsp = {DIR_TAB[i].slot_out, DIR_TAB[i].count, DIR_TAB[i].status};
      send_beat(rq, DIR_TAB[i].typed, row_rsp);
    end

    // random streams, with a full drain of the pool halfway
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 150 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
      if (i == 200) rx_hold_req = 1'b1;
      if (i == RAND_ITEMS / 2) full_pool_cycle();
      send_beat(pick_request(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (rsp_due_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("slot_pool_batch_queue_unit: match");
    end else begin
      $display("slot_pool_batch_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
